@@ rtl/cpl_pkg.sv @@
// ----------------------------------------------------------------------------
// cpl_pkg
// Shared types and constants for the circular positional list: request and
// response structs, mode and status codes, node store write bundle.
// ----------------------------------------------------------------------------
package cpl_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 8;
    localparam int LEN_W    = 5;
    localparam int VAL_W    = 32;
    localparam int CMP_W    = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_DUMP   = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]              mode;
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        position;
    } t_req;

    typedef struct packed {
        t_status                 status;
        logic signed [VAL_W-1:0] element;
        logic [LEN_W-1:0]        length;
        logic                    final_flag;
    } t_rsp;

    typedef struct packed {
        logic             val_we;
        logic [IDX_W-1:0] val_addr;
        logic [VAL_W-1:0] val_data;
        logic             link_we;
        logic [IDX_W-1:0] link_addr;
        logic [IDX_W-1:0] link_data;
    } t_store_wr;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_WALK,
        S_WRITE,
        S_DUMP,
        S_RESP
    } t_state;

endpackage

@@ rtl/circular_positional_list_top.sv @@
// ----------------------------------------------------------------------------
// circular_positional_list_top
// Bounded singly circular list of signed values with positional insert,
// positional delete and an in-order dump.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+--------
//   request  | i_req_valid / o_req_ready | i_req
//   response | o_rsp_valid / i_rsp_ready | o_rsp
//
// One request at a time. A request settled at decode (rejected, first insert,
// last delete, unused mode) goes straight from decode to the response. Insert
// at either end and delete at the head start from the tail with no hops; any
// other insert or delete at position p first walks the links from the head,
// one hop per cycle through the node store read port. A dump of n elements
// gives n responses, the last one flagged final. Reset frees every node and
// empties the list. A stalled response holds the sequencer; a new request is taken as soon as the sequencer idles.
// ----------------------------------------------------------------------------
module circular_positional_list_top
    import cpl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_rsp o_rsp
);

    t_state            r_state, n_state;
    t_req              r_req, n_req;
    logic [CAPACITY-1:0] r_free, n_free;
    logic [IDX_W-1:0]  r_head, n_head;
    logic [IDX_W-1:0]  r_tail, n_tail;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [IDX_W-1:0]  r_cur, n_cur;
    logic [IDX_W-1:0]  r_left, n_left;
    logic [IDX_W-1:0]  r_prev, n_prev;
    logic [IDX_W-1:0]  r_node, n_node;
    logic [CNT_W-1:0]  r_k, n_k;
    t_status           r_status, n_status;
    logic              r_rsp_valid, n_rsp_valid;
    t_rsp              r_rsp, n_rsp;

    t_store_wr         wr;
    logic [IDX_W-1:0]  rd_addr;
    logic [VAL_W-1:0]  rd_val;
    logic [IDX_W-1:0]  rd_link;

    logic              out_free;
    logic [CMP_W-1:0]  pos_x, cnt_x;
    logic              ins_bad, is_full, del_bad, at_edge, pos_first, pos_last;
    logic              dump_last;
    logic [IDX_W-1:0]  low_free;
    logic [IDX_W-1:0]  start_node, start_hops;

    cpl_store u_store (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd_addr (rd_addr),
        .o_val     (rd_val),
        .o_link    (rd_link)
    );

    assign out_free  = !r_rsp_valid || i_rsp_ready;
    assign pos_x     = CMP_W'(r_req.position);
    assign cnt_x     = CMP_W'(r_count);
    assign ins_bad   = (pos_x == '0) || (pos_x > cnt_x + CMP_W'(1));
    assign is_full   = (r_count == CNT_W'(CAPACITY));
    assign del_bad   = (pos_x == '0) || (pos_x > cnt_x);
    assign pos_first = (pos_x == CMP_W'(1));
    assign pos_last  = (r_req.mode == MODE_INSERT) ? (pos_x == cnt_x + CMP_W'(1))
                                                   : (pos_x == cnt_x);
    assign at_edge   = pos_first || ((r_req.mode == MODE_INSERT) && pos_last);
    assign start_node = at_edge ? r_tail : r_head;
    assign start_hops = at_edge ? '0 : IDX_W'(pos_x - CMP_W'(2));
    assign dump_last = (r_k + CNT_W'(1) == r_count);

    always_comb begin
        low_free = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (r_free[i]) begin
                low_free = IDX_W'(i);
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                case (r_req.mode)
                    MODE_INSERT: begin
                        if (ins_bad || is_full || r_count == '0) begin
                            n_state = S_RESP;
                        end else begin
                            n_state = S_WALK;
                        end
                    end
                    MODE_DELETE: begin
                        if (r_count == '0 || del_bad || r_count == CNT_W'(1)) begin
                            n_state = S_RESP;
                        end else begin
                            n_state = S_WALK;
                        end
                    end
                    MODE_DUMP: begin
                        n_state = (r_count == '0) ? S_RESP : S_DUMP;
                    end
                    default: n_state = S_RESP;
                endcase
            end
            S_WALK: begin
                if (r_left == '0) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: n_state = S_RESP;
            S_DUMP: begin
                if (out_free && dump_last) begin
                    n_state = S_IDLE;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_req       = r_req;
        n_free      = r_free;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_cur       = r_cur;
        n_left      = r_left;
        n_prev      = r_prev;
        n_node      = r_node;
        n_k         = r_k;
        n_status    = r_status;
        n_rsp_valid = r_rsp_valid && !i_rsp_ready;
        n_rsp       = r_rsp;
        rd_addr     = r_cur;
        wr          = '0;
        o_req_ready = 1'b0;

        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    n_req = i_req;
                end
            end
            S_DECIDE: begin
                n_status = ST_OK;
                n_cur    = start_node;
                n_left   = start_hops;
                rd_addr  = start_node;
                case (r_req.mode)
                    MODE_INSERT: begin
                        n_node = low_free;
                        if (ins_bad) begin
                            n_status = ST_BADPOS;
                        end else if (is_full) begin
                            n_status = ST_FULL;
                        end else if (r_count == '0) begin
                            wr.val_we    = 1'b1;
                            wr.val_addr  = low_free;
                            wr.val_data  = r_req.value;
                            wr.link_we   = 1'b1;
                            wr.link_addr = low_free;
                            wr.link_data = low_free;
                            n_head       = low_free;
                            n_tail       = low_free;
                            n_free[low_free] = 1'b0;
                            n_count      = CNT_W'(1);
                        end
                    end
                    MODE_DELETE: begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                        end else if (del_bad) begin
                            n_status = ST_BADPOS;
                        end else if (r_count == CNT_W'(1)) begin
                            n_free[r_head] = 1'b1;
                            n_head  = '0;
                            n_tail  = '0;
                            n_count = '0;
                        end
                    end
                    MODE_DUMP: begin
                        n_cur   = r_head;
                        rd_addr = r_head;
                        n_k     = '0;
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                        end
                    end
                    default: n_status = ST_BADPOS;
                endcase
            end
            S_WALK: begin
                rd_addr = rd_link;
                if (r_left != '0) begin
                    n_cur  = rd_link;
                    n_left = r_left - IDX_W'(1);
                end else begin
                    n_prev = r_cur;
                    if (r_req.mode == MODE_INSERT) begin
                        wr.val_we    = 1'b1;
                        wr.val_addr  = r_node;
                        wr.val_data  = r_req.value;
                        wr.link_we   = 1'b1;
                        wr.link_addr = r_node;
                        wr.link_data = rd_link;
                    end else begin
                        n_node = rd_link;
                    end
                end
            end
            S_WRITE: begin
                wr.link_we   = 1'b1;
                wr.link_addr = r_prev;
                if (r_req.mode == MODE_INSERT) begin
                    wr.link_data = r_node;
                    if (pos_first) begin
                        n_head = r_node;
                    end
                    if (pos_last) begin
                        n_tail = r_node;
                    end
                    n_free[r_node] = 1'b0;
                    n_count = r_count + CNT_W'(1);
                end else begin
                    wr.link_data = rd_link;
                    if (pos_first) begin
                        n_head = rd_link;
                    end
                    if (pos_last) begin
                        n_tail = r_prev;
                    end
                    n_free[r_node] = 1'b1;
                    n_count = r_count - CNT_W'(1);
                end
            end
            S_DUMP: begin
                if (out_free) begin
                    rd_addr               = rd_link;
                    n_cur                 = rd_link;
                    n_k                   = r_k + CNT_W'(1);
                    n_rsp_valid           = 1'b1;
                    n_rsp.status          = ST_OK;
                    n_rsp.element         = rd_val;
                    n_rsp.length          = LEN_W'(r_count);
                    n_rsp.final_flag      = dump_last;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_rsp_valid      = 1'b1;
                    n_rsp.status     = r_status;
                    n_rsp.element    = '0;
                    n_rsp.length     = LEN_W'(r_count);
                    n_rsp.final_flag = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_free      <= '1;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_free      <= n_free;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_cur    <= n_cur;
        r_left   <= n_left;
        r_prev   <= n_prev;
        r_node   <= n_node;
        r_k      <= n_k;
        r_status <= n_status;
        r_rsp    <= n_rsp;
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

@@ rtl/cpl_store.sv @@
// ----------------------------------------------------------------------------
// cpl_store
// Node store: value memory and link memory, one write port each, one shared
// read address, registered read data.
// ----------------------------------------------------------------------------
module cpl_store
    import cpl_pkg::*;
(
    input  logic             i_clk,
    input  t_store_wr        i_wr,
    input  logic [IDX_W-1:0] i_rd_addr,
    output logic [VAL_W-1:0] o_val,
    output logic [IDX_W-1:0] o_link
);

    logic [VAL_W-1:0] mem_val  [CAPACITY];
    logic [IDX_W-1:0] mem_link [CAPACITY];
    logic [VAL_W-1:0] r_val;
    logic [IDX_W-1:0] r_link;

    always_ff @(posedge i_clk) begin
        if (i_wr.val_we) begin
            mem_val[i_wr.val_addr] <= i_wr.val_data;
        end
        if (i_wr.link_we) begin
            mem_link[i_wr.link_addr] <= i_wr.link_data;
        end
        r_val  <= mem_val[i_rd_addr];
        r_link <= mem_link[i_rd_addr];
    end

    assign o_val  = r_val;
    assign o_link = r_link;

endmodule
